// ----- rtl/core/pts_pkg.sv -----
// Shared types and constants for the priority task scheduler.
// Used by pts_ctrl, pts_dp and the top level; no dependencies.
`default_nettype none

package pts_pkg;

   // event kind codes carried by req_kind
   localparam logic [2:0] KIND_MAKE_READY   = 3'd0;
   localparam logic [2:0] KIND_MAKE_UNREADY = 3'd1;
   localparam logic [2:0] KIND_DELAY        = 3'd2;
   localparam logic [2:0] KIND_TICK         = 3'd3;
   localparam logic [2:0] KIND_LOCK         = 3'd4;
   localparam logic [2:0] KIND_UNLOCK       = 3'd5;

   localparam logic [7:0] LOCK_MAX = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_RESULT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;    // capture the request word
      logic exec;        // apply the immediate part of the event
      logic scan_start;  // clear scan pointer and search result
      logic scan_step;   // read one delay counter, advance pointer
      logic commit;      // apply the schedule decision
      logic load_rsp;    // load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_sched; // event ends with a schedule
      logic scan_last;   // pointer is at the last slot
      logic rsp_free;    // result register can take a word
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/pts_ctrl.sv -----
// Sequencer for the scheduler: accepts a request word, walks the
// execute / scan / commit / result steps. Uses pts_pkg.
`default_nettype none

module pts_ctrl
   import pts_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.needs_sched) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last slot is processed this cycle
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/pts_dp.sv -----
// Scheduler datapath: ready/delayed masks, delay counter memory, lock
// count, running task, slot scan and result register. Uses pts_pkg.
`default_nettype none

module pts_dp
   import pts_pkg::*;
#(
   parameter int TASK_COUNT  = 32,
   parameter int DELAY_WIDTH = 16
)
(
   input  wire         clock,
   input  wire         reset,
   input  wire  [2:0]  req_kind,
   input  wire  [4:0]  req_task_index,
   input  wire  [15:0] req_delay_ticks,
   input  wire         rsp_stall,
   output logic        rsp_valid,
   output logic        rsp_switched,
   output logic        rsp_running_valid,
   output logic [4:0]  rsp_running_task,
   output logic [31:0] rsp_ready_mask,
   output logic [7:0]  rsp_lock_level,
   input  cmd_type     cmd,
   output status_type  status
);

   localparam int SLOT_W = $clog2(TASK_COUNT);
   localparam int DW     = DELAY_WIDTH;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_COUNT - 1);
   localparam logic [6:0]        TASK_LIM  = 7'(TASK_COUNT);

   // request word
   logic [2:0]  kind_ff;
   logic [4:0]  idx_ff;
   logic [15:0] dly_ff;

   // scheduler state
   logic [TASK_COUNT-1:0] ready_ff, ready_in;
   logic [TASK_COUNT-1:0] delayed_ff, delayed_in;
   logic [7:0]            lock_ff, lock_in;
   logic [SLOT_W-1:0]     cur_slot_ff, cur_slot_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic                  sw_ff, sw_in;

   // scan
   logic [SLOT_W-1:0] scan_ff, scan_in;
   logic [SLOT_W-1:0] proc_ff;
   logic              proc_valid_ff;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] found_slot_ff, found_slot_in;

   // delay counters
   logic [DW-1:0] mem [TASK_COUNT];
   logic [DW-1:0] rd_data_ff;
   logic          mem_we;
   logic [SLOT_W-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_switched_ff;
   logic        rsp_running_valid_ff;
   logic [4:0]  rsp_running_task_ff;
   logic [31:0] rsp_ready_mask_ff;
   logic [7:0]  rsp_lock_level_ff;

   logic                  idx_in_range;
   logic [SLOT_W+4:0]     idx_ext;
   logic [SLOT_W-1:0]     idx_slot;
   logic [DW+15:0]        dly_ext;
   logic [DW-1:0]         dly_fit;
   logic                  is_tick;
   logic                  proc_hit;
   logic [DW-1:0]         dec;
   logic                  wake;
   logic                  proc_ready;
   logic                  delay_ok;
   logic                  changed;
   logic [SLOT_W+4:0]     cur_ext;
   logic [TASK_COUNT+31:0] ready_ext;

   assign idx_in_range = ({2'b00, idx_ff} < TASK_LIM);
   assign idx_ext      = {{SLOT_W{1'b0}}, idx_ff};
   assign idx_slot     = idx_ext[SLOT_W-1:0];

   // zero counts as one tick; saturate to the counter width
   assign dly_ext = {{DW{1'b0}}, dly_ff};
   always_comb begin
      if (dly_ff == 16'd0) begin
         dly_fit = {{(DW-1){1'b0}}, 1'b1};
      end else if (dly_ext > {16'd0, {DW{1'b1}}}) begin
         dly_fit = {DW{1'b1}};
      end else begin
         dly_fit = dly_ext[DW-1:0];
      end
   end

   assign is_tick    = (kind_ff == KIND_TICK);
   assign delay_ok   = (kind_ff == KIND_DELAY) && cur_valid_ff;
   assign proc_hit   = proc_valid_ff && is_tick && delayed_ff[proc_ff];
   assign dec        = (rd_data_ff == '0) ? '0 : rd_data_ff - 1'b1;
   assign wake       = proc_hit && (dec == '0);
   assign proc_ready = ready_ff[proc_ff] | wake;

   assign status.needs_sched = is_tick || delay_ok
                               || ((kind_ff == KIND_UNLOCK) && (lock_ff == 8'd1));
   assign status.scan_last   = (scan_ff == LAST_SLOT);
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign changed = (found_ff != cur_valid_ff)
                    || (found_ff && (found_slot_ff != cur_slot_ff));

   always_comb begin
      ready_in      = ready_ff;
      delayed_in    = delayed_ff;
      lock_in       = lock_ff;
      cur_slot_in   = cur_slot_ff;
      cur_valid_in  = cur_valid_ff;
      sw_in         = sw_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      mem_we        = 1'b0;
      mem_waddr     = proc_ff;
      mem_wdata     = dec;

      if (cmd.load_req) begin
         sw_in = 1'b0;
      end

      if (cmd.exec) begin
         case (kind_ff)
            KIND_MAKE_READY: begin
               if (idx_in_range) begin
                  ready_in[idx_slot] = 1'b1;
               end
            end
            KIND_MAKE_UNREADY: begin
               if (idx_in_range) begin
                  ready_in[idx_slot] = 1'b0;
               end
            end
            KIND_DELAY: begin
               if (cur_valid_ff) begin
                  ready_in[cur_slot_ff]   = 1'b0;
                  delayed_in[cur_slot_ff] = 1'b1;
                  mem_we    = 1'b1;
                  mem_waddr = cur_slot_ff;
                  mem_wdata = dly_fit;
               end
            end
            KIND_LOCK: begin
               if (lock_ff != LOCK_MAX) begin
                  lock_in = lock_ff + 8'd1;
               end
            end
            KIND_UNLOCK: begin
               if (lock_ff != 8'd0) begin
                  lock_in = lock_ff - 8'd1;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.scan_start) begin
         scan_in       = '0;
         found_in      = 1'b0;
         found_slot_in = '0;
      end

      if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
      end

      // process the slot whose counter was read last cycle
      if (proc_valid_ff) begin
         if (proc_hit) begin
            mem_we    = 1'b1;
            mem_waddr = proc_ff;
            mem_wdata = dec;
         end
         if (wake) begin
            delayed_in[proc_ff] = 1'b0;
            ready_in[proc_ff]   = 1'b1;
         end
         if (!found_ff && proc_ready) begin
            found_in      = 1'b1;
            found_slot_in = proc_ff;
         end
      end

      if (cmd.commit && (lock_ff == 8'd0)) begin
         sw_in        = changed;
         cur_valid_in = found_ff;
         cur_slot_in  = found_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff      <= '0;
         delayed_ff    <= '0;
         lock_ff       <= '0;
         cur_slot_ff   <= '0;
         cur_valid_ff  <= 1'b0;
         proc_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         ready_ff      <= ready_in;
         delayed_ff    <= delayed_in;
         lock_ff       <= lock_in;
         cur_slot_ff   <= cur_slot_in;
         cur_valid_ff  <= cur_valid_in;
         proc_valid_ff <= cmd.scan_step;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      sw_ff         <= sw_in;
      scan_ff       <= scan_in;
      found_slot_ff <= found_slot_in;
      if (cmd.scan_step) begin
         proc_ff <= scan_ff;
      end
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         idx_ff  <= req_task_index;
         dly_ff  <= req_delay_ticks;
      end
   end

   // delay counter memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.scan_step) begin
         rd_data_ff <= mem[scan_ff];
      end
   end

   // result register
   assign cur_ext   = {5'd0, cur_slot_ff};
   assign ready_ext = {32'd0, ready_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_switched_ff      <= sw_ff;
         rsp_running_valid_ff <= cur_valid_ff;
         rsp_running_task_ff  <= cur_ext[4:0];
         rsp_ready_mask_ff    <= ready_ext[31:0];
         rsp_lock_level_ff    <= lock_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_switched      = rsp_switched_ff;
   assign rsp_running_valid = rsp_running_valid_ff;
   assign rsp_running_task  = rsp_running_task_ff;
   assign rsp_ready_mask    = rsp_ready_mask_ff;
   assign rsp_lock_level    = rsp_lock_level_ff;

endmodule

`default_nettype wire

// ----- rtl/core/priority_task_scheduler_with_delays_unit.sv -----
// Top level of the priority task scheduler with tick delays.
// Instantiates pts_ctrl and pts_dp; uses pts_pkg.
//
// One task per priority slot, slot 0 highest. Each request word on the
// req_ channel is one event: make ready, make unready, delay the running
// task, tick, lock or unlock (req_kind). Every event returns exactly one
// response word on the rsp_ channel with the switch flag, the running
// task, the ready mask and the lock level after the event.
// Make ready, make unready, lock, and an unlock that leaves the lock held
// or a delay with no running task go from execute straight to the
// result step. Tick, delay and an unlock that releases the lock also
// scan: the controller walks every slot, one per cycle, through the
// single read port of the delay counter memory, counting down delayed
// slots on a tick and finding the highest-priority ready slot.
// req_stall is low only while the controller is idle; a word is taken
// when req_valid is high and req_stall low. The response sits in an
// output register; while rsp_stall is high it holds, and a finished
// event waits in its last step until the register frees up.
// Reset (synchronous, active high) clears the ready and delayed masks,
// lock count and running task and empties the output register. Delay
// counters need no clearing: a counter is used only after it is loaded.
`default_nettype none

module priority_task_scheduler_with_delays_unit
   import pts_pkg::*;
#(
   parameter int TASK_COUNT  = 32,
   parameter int DELAY_WIDTH = 16
)
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_kind,
   input  wire  [4:0]  req_task_index,
   input  wire  [15:0] req_delay_ticks,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_switched,
   output logic        rsp_running_valid,
   output logic [4:0]  rsp_running_task,
   output logic [31:0] rsp_ready_mask,
   output logic [7:0]  rsp_lock_level
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // masks, counters, scan and output register
   pts_dp #(
      .TASK_COUNT  (TASK_COUNT),
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_kind          (req_kind),
      .req_task_index    (req_task_index),
      .req_delay_ticks   (req_delay_ticks),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_switched      (rsp_switched),
      .rsp_running_valid (rsp_running_valid),
      .rsp_running_task  (rsp_running_task),
      .rsp_ready_mask    (rsp_ready_mask),
      .rsp_lock_level    (rsp_lock_level),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

`default_nettype wire
